// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define LCOS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define LCOS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lcos_pkg.sv =====
// Types and constants shared by the least-cost option selector.
package lcos_pkg;

    localparam int ID_W       = 4;
    localparam int NUM_IDS    = 16;
    localparam int CNT_W      = 5;
    localparam int TICKS_W    = 32;
    localparam int ROUNDS_W   = 16;
    localparam int REQ_CNT_W  = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OPTION_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_ROUNDS  = 2'd2;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_REPORT  = 1'b1;

    localparam logic MODE_SWITCH = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    typedef struct packed {
        logic               action;
        logic [ID_W-1:0]    option_id;
        logic [TICKS_W-1:0] cost_ticks;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] chosen_id;
        logic            last;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]    active_count;
        logic                policy_mode;
        logic [ROUNDS_W-1:0] test_rounds;
    } cfg_t;

endpackage

// ===== rtl/core/lcos_ram.sv =====
// Single-port-read, single-port-write synchronous RAM with per-entry valid bits.
module lcos_ram #(
    parameter int DEPTH          = 16,
    parameter int WIDTH          = 4,
    parameter bit IDENTITY_RESET = 1'b0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic [AW-1:0]    raddr_reg;
    logic             hit_reg;
    logic [WIDTH-1:0] fill;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= ram_reg[raddr];
            raddr_reg <= raddr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    // An entry never written since reset or clear reads as its reset value.
    assign fill  = IDENTITY_RESET ? WIDTH'(raddr_reg) : '0;
    assign rdata = hit_reg ? rdata_reg : fill;

endmodule

// ===== rtl/core/lcos_cfg.sv =====
// Configuration registers of the least-cost option selector.
module lcos_cfg #(
    parameter int MAX_OPTIONS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lcos_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcos_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output lcos_pkg::cfg_t                    cfg,
    output logic                              rank_clear
);
    import lcos_pkg::*;

    localparam int ID_LIMIT = (MAX_OPTIONS < NUM_IDS) ? MAX_OPTIONS : NUM_IDS;

    logic [CNT_W-1:0]    count_reg;
    logic                mode_reg;
    logic [ROUNDS_W-1:0] rounds_reg;
    logic [CNT_W-1:0]    wr_count;
    logic [CNT_W-1:0]    clamped_count;

    assign wr_count = cfg_wdata[CNT_W-1:0];

    // The active count is clamped once, when the register is written.
    always_comb begin
        if (wr_count == '0) begin
            clamped_count = CNT_W'(1);
        end else if (wr_count > CNT_W'(ID_LIMIT)) begin
            clamped_count = CNT_W'(ID_LIMIT);
        end else begin
            clamped_count = wr_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= CNT_W'(1);
            mode_reg   <= MODE_SWITCH;
            rounds_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OPTION_COUNT: count_reg  <= clamped_count;
                REG_POLICY_MODE:  mode_reg   <= cfg_wdata[0];
                REG_TEST_ROUNDS:  rounds_reg <= cfg_wdata[ROUNDS_W-1:0];
                default: ;
            endcase
        end
    end

    // Rewriting the option count puts the ranking back into id order.
    assign rank_clear = cfg_wr_en && (cfg_index == REG_OPTION_COUNT);

    assign cfg.active_count = count_reg;
    assign cfg.policy_mode  = mode_reg;
    assign cfg.test_rounds  = rounds_reg;

endmodule

// ===== rtl/core/lcos_seq.sv =====
// Sequencer: reads, updates and writes back the rank and cost memories per transaction.
module lcos_seq #(
    parameter int MAX_OPTIONS = 16,
    parameter int COST_BITS   = 48
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lcos_pkg::cfg_t                     cfg,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lcos_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lcos_pkg::out_item_t                m_data,
    output logic                               rank_rd_en,
    output logic [$clog2(MAX_OPTIONS)-1:0]     rank_raddr,
    input  logic [lcos_pkg::ID_W-1:0]          rank_rdata,
    output logic                               rank_we,
    output logic [$clog2(MAX_OPTIONS)-1:0]     rank_waddr,
    output logic [lcos_pkg::ID_W-1:0]          rank_wdata,
    output logic                               cost_rd_en,
    output logic [$clog2(MAX_OPTIONS)-1:0]     cost_raddr,
    input  logic [COST_BITS-1:0]               cost_rdata,
    output logic                               cost_we,
    output logic [$clog2(MAX_OPTIONS)-1:0]     cost_waddr,
    output logic [COST_BITS-1:0]               cost_wdata
);
    import lcos_pkg::*;

    localparam int AW    = $clog2(MAX_OPTIONS);
    localparam int SUM_W = ((COST_BITS > TICKS_W) ? COST_BITS : TICKS_W) + 1;

    typedef enum logic [15:0] {
        S_IDLE        = 16'h0001,
        S_REQ_EMIT    = 16'h0002,
        S_TEST_EMIT   = 16'h0004,
        S_MIN         = 16'h0008,
        S_COMMIT_EMIT = 16'h0010,
        S_FRONT_ID    = 16'h0020,
        S_CHARGE      = 16'h0040,
        S_FIRST_ID    = 16'h0080,
        S_FIRST_COST  = 16'h0100,
        S_MID_ID      = 16'h0200,
        S_MID_COST    = 16'h0400,
        S_NEXT_ID     = 16'h0800,
        S_NEXT_COST   = 16'h1000,
        S_SHIFT_RD    = 16'h2000,
        S_SHIFT_WR    = 16'h4000,
        S_PLACE       = 16'h8000
    } state_t;

    state_t               state_reg, state_next;
    logic [TICKS_W-1:0]   ticks_reg, ticks_next;
    logic [ID_W-1:0]      tgt_reg, tgt_next;
    logic [COST_BITS-1:0] c0_reg, c0_next;
    logic [ID_W-1:0]      best_reg, best_next;
    logic [COST_BITS-1:0] best_cost_reg, best_cost_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     l_reg, l_next;
    logic [CNT_W-1:0]     r_reg, r_next;
    logic [CNT_W-1:0]     m_reg, m_next;
    logic [REQ_CNT_W-1:0] req_cnt_reg, req_cnt_next;
    logic [ID_W-1:0]      commit_id_reg, commit_id_next;
    logic                 commit_valid_reg, commit_valid_next;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic                 out_free;
    logic                 emit;
    out_item_t            emit_data;
    logic [CNT_W-1:0]     n;
    logic [SUM_W-1:0]     sum;
    logic [COST_BITS-1:0] sat_sum;
    logic                 le;
    logic [CNT_W-1:0]     l_upd, r_upd;
    logic [CNT_W:0]       pair_upd, pair_cur;
    logic [CNT_W-1:0]     mid_upd, mid_cur;
    logic                 stuck;
    logic                 take;
    logic                 testing;

    assign n        = cfg.active_count;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Saturating accumulate of the measured ticks into the fetched total.
    assign sum     = SUM_W'(cost_rdata) + SUM_W'(ticks_reg);
    assign sat_sum = (sum[SUM_W-1:COST_BITS] != '0) ? {COST_BITS{1'b1}}
                                                    : sum[COST_BITS-1:0];

    // Binary-search step on the cost fetched at the midpoint.
    assign le       = (cost_rdata <= c0_reg);
    assign l_upd    = le ? m_reg : l_reg;
    assign r_upd    = le ? r_reg : m_reg;
    assign pair_upd = {1'b0, l_upd} + {1'b0, r_upd};
    assign pair_cur = {1'b0, l_reg} + {1'b0, r_reg};
    assign mid_upd  = pair_upd[CNT_W:1];
    assign mid_cur  = pair_cur[CNT_W:1];
    // When the bounds stop moving the search would repeat the same midpoint forever.
    assign stuck    = (l_upd == l_reg) && (r_upd == r_reg);

    assign take    = (idx_reg == '0) || (cost_rdata < best_cost_reg);
    assign testing = (req_cnt_reg < {1'b0, cfg.test_rounds});

    always_comb begin
        state_next        = state_reg;
        ticks_next        = ticks_reg;
        tgt_next          = tgt_reg;
        c0_next           = c0_reg;
        best_next         = best_reg;
        best_cost_next    = best_cost_reg;
        idx_next          = idx_reg;
        l_next            = l_reg;
        r_next            = r_reg;
        m_next            = m_reg;
        req_cnt_next      = req_cnt_reg;
        commit_id_next    = commit_id_reg;
        commit_valid_next = commit_valid_reg;
        rank_rd_en        = 1'b0;
        rank_raddr        = '0;
        rank_we           = 1'b0;
        rank_waddr        = '0;
        rank_wdata        = '0;
        cost_rd_en        = 1'b0;
        cost_raddr        = '0;
        cost_we           = 1'b0;
        cost_waddr        = '0;
        cost_wdata        = '0;
        emit              = 1'b0;
        emit_data         = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ticks_next = s_data.cost_ticks;
                    if (s_data.action == ACT_REPORT) begin
                        if (cfg.policy_mode == MODE_SWITCH) begin
                            rank_rd_en = 1'b1;
                            state_next = S_FRONT_ID;
                        end else if ({1'b0, s_data.option_id} < n) begin
                            cost_rd_en = 1'b1;
                            cost_raddr = AW'(s_data.option_id);
                            tgt_next   = s_data.option_id;
                            state_next = S_CHARGE;
                        end
                    end else if (cfg.policy_mode == MODE_SWITCH) begin
                        rank_rd_en = 1'b1;
                        state_next = S_REQ_EMIT;
                    end else begin
                        if (req_cnt_reg != {REQ_CNT_W{1'b1}}) begin
                            req_cnt_next = req_cnt_reg + 1'b1;
                        end
                        idx_next = '0;
                        if (testing) begin
                            state_next = S_TEST_EMIT;
                        end else if (commit_valid_reg) begin
                            state_next = S_COMMIT_EMIT;
                        end else begin
                            cost_rd_en = 1'b1;
                            state_next = S_MIN;
                        end
                    end
                end
            end
            S_REQ_EMIT: begin
                emit      = 1'b1;
                emit_data = '{chosen_id: rank_rdata, last: 1'b1};
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_TEST_EMIT: begin
                emit      = 1'b1;
                emit_data = '{chosen_id: ID_W'(idx_reg), last: (idx_reg + 1'b1 == n)};
                if (out_free) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == n) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MIN: begin
                best_next      = take ? ID_W'(idx_reg) : best_reg;
                best_cost_next = take ? cost_rdata : best_cost_reg;
                if (idx_reg + 1'b1 == n) begin
                    commit_id_next    = best_next;
                    commit_valid_next = 1'b1;
                    state_next        = S_COMMIT_EMIT;
                end else begin
                    cost_rd_en = 1'b1;
                    cost_raddr = AW'(idx_reg + 1'b1);
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_COMMIT_EMIT: begin
                emit      = 1'b1;
                emit_data = '{chosen_id: commit_id_reg, last: 1'b1};
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_FRONT_ID: begin
                tgt_next   = rank_rdata;
                cost_rd_en = 1'b1;
                cost_raddr = AW'(rank_rdata);
                state_next = S_CHARGE;
            end
            S_CHARGE: begin
                cost_we    = 1'b1;
                cost_waddr = AW'(tgt_reg);
                cost_wdata = sat_sum;
                c0_next    = sat_sum;
                if ((cfg.policy_mode == MODE_SELECT) || (n < CNT_W'(2))) begin
                    state_next = S_IDLE;
                end else begin
                    rank_rd_en = 1'b1;
                    rank_raddr = AW'(1);
                    state_next = S_FIRST_ID;
                end
            end
            S_FIRST_ID, S_MID_ID, S_NEXT_ID: begin
                cost_rd_en = 1'b1;
                cost_raddr = AW'(rank_rdata);
                case (state_reg)
                    S_FIRST_ID: state_next = S_FIRST_COST;
                    S_MID_ID:   state_next = S_MID_COST;
                    default:    state_next = S_NEXT_COST;
                endcase
            end
            S_FIRST_COST: begin
                // The front entry moves only if it now costs more than the second.
                if (c0_reg > cost_rdata) begin
                    l_next     = '0;
                    r_next     = n;
                    m_next     = n >> 1;
                    rank_rd_en = 1'b1;
                    rank_raddr = AW'(n >> 1);
                    state_next = S_MID_ID;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_MID_COST: begin
                l_next = l_upd;
                r_next = r_upd;
                idx_next = '0;
                if (({1'b0, m_reg} + 1'b1 >= {1'b0, n}) || stuck) begin
                    state_next = (m_reg == '0) ? S_PLACE : S_SHIFT_RD;
                end else if (le) begin
                    rank_rd_en = 1'b1;
                    rank_raddr = AW'(m_reg + 1'b1);
                    state_next = S_NEXT_ID;
                end else begin
                    m_next     = mid_upd;
                    rank_rd_en = 1'b1;
                    rank_raddr = AW'(mid_upd);
                    state_next = S_MID_ID;
                end
            end
            S_NEXT_COST: begin
                idx_next = '0;
                if (c0_reg < cost_rdata) begin
                    state_next = (m_reg == '0) ? S_PLACE : S_SHIFT_RD;
                end else begin
                    m_next     = mid_cur;
                    rank_rd_en = 1'b1;
                    rank_raddr = AW'(mid_cur);
                    state_next = S_MID_ID;
                end
            end
            S_SHIFT_RD: begin
                rank_rd_en = 1'b1;
                rank_raddr = AW'(idx_reg + 1'b1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                rank_we    = 1'b1;
                rank_waddr = AW'(idx_reg);
                rank_wdata = rank_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == m_reg) ? S_PLACE : S_SHIFT_RD;
            end
            S_PLACE: begin
                rank_we    = 1'b1;
                rank_waddr = AW'(m_reg);
                rank_wdata = tgt_reg;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            req_cnt_reg      <= '0;
            commit_id_reg    <= '0;
            commit_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            req_cnt_reg      <= req_cnt_next;
            commit_id_reg    <= commit_id_next;
            commit_valid_reg <= commit_valid_next;
            if (emit && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ticks_reg     <= ticks_next;
        tgt_reg       <= tgt_next;
        c0_reg        <= c0_next;
        best_reg      <= best_next;
        best_cost_reg <= best_cost_next;
        idx_reg       <= idx_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        m_reg         <= m_next;
        if (emit && out_free) begin
            m_data_reg <= emit_data;
        end
    end

endmodule

// ===== rtl/core/least_cost_option_selector.sv =====
// Least-cost option selector: picks which of several equivalent options to run.
//
// Input channel (s_valid/s_ready/s_data): a request asks for option ids, a report
// adds measured ticks, saturating, to one option's total cost. Result channel
// (m_valid/m_ready/m_data) returns chosen ids, the final id of a request marked by last.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata), used while idle.
// One transaction is worked on at a time; s_ready is high only while nothing is in work.
// A switch-mode request reads the front of the rank memory, then hands over its id; a
// select-mode request in its test rounds gives one id per cycle while the receiver takes
// them; the first committed choice comes from a scan of the cost memory. A select-mode
// report reads and writes back its option's cost, or is dropped when its id is not in use.
// In a switch-mode report every ranked entry it examines is a rank read followed by a cost
// read, each on its memory's single read port, and moving the front entry back takes a
// rank read and a rank write per position.
// A result waits in an output register while the next transaction is accepted; a stalled
// receiver holds the sequencer only when it has a further id to hand over.
// Reset is synchronous and clears the control state: per-entry valid bits make the
// rank memory read as id order and the cost memory read as zero until written.
module least_cost_option_selector #(
    parameter int MAX_OPTIONS = 16,
    parameter int COST_BITS   = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lcos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcos_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lcos_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lcos_pkg::out_item_t             m_data
);
    import lcos_pkg::*;

    localparam int AW = $clog2(MAX_OPTIONS);

    cfg_t                 cfg;
    logic                 rank_clear;
    logic                 rank_rd_en;
    logic [AW-1:0]        rank_raddr;
    logic [ID_W-1:0]      rank_rdata;
    logic                 rank_we;
    logic [AW-1:0]        rank_waddr;
    logic [ID_W-1:0]      rank_wdata;
    logic                 cost_rd_en;
    logic [AW-1:0]        cost_raddr;
    logic [COST_BITS-1:0] cost_rdata;
    logic                 cost_we;
    logic [AW-1:0]        cost_waddr;
    logic [COST_BITS-1:0] cost_wdata;

    lcos_cfg #(
        .MAX_OPTIONS(MAX_OPTIONS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .rank_clear (rank_clear)
    );

    lcos_ram #(
        .DEPTH          (MAX_OPTIONS),
        .WIDTH          (ID_W),
        .IDENTITY_RESET (1'b1)
    ) u_rank_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (rank_clear),
        .rd_en   (rank_rd_en),
        .raddr   (rank_raddr),
        .rdata   (rank_rdata),
        .we      (rank_we),
        .waddr   (rank_waddr),
        .wdata   (rank_wdata)
    );

    lcos_ram #(
        .DEPTH          (MAX_OPTIONS),
        .WIDTH          (COST_BITS),
        .IDENTITY_RESET (1'b0)
    ) u_cost_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (1'b0),
        .rd_en   (cost_rd_en),
        .raddr   (cost_raddr),
        .rdata   (cost_rdata),
        .we      (cost_we),
        .waddr   (cost_waddr),
        .wdata   (cost_wdata)
    );

    lcos_seq #(
        .MAX_OPTIONS (MAX_OPTIONS),
        .COST_BITS   (COST_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .rank_rd_en (rank_rd_en),
        .rank_raddr (rank_raddr),
        .rank_rdata (rank_rdata),
        .rank_we    (rank_we),
        .rank_waddr (rank_waddr),
        .rank_wdata (rank_wdata),
        .cost_rd_en (cost_rd_en),
        .cost_raddr (cost_raddr),
        .cost_rdata (cost_rdata),
        .cost_we    (cost_we),
        .cost_waddr (cost_waddr),
        .cost_wdata (cost_wdata)
    );

endmodule

// ===== rtl/core/lcos_checker.sv =====
// Port-level assertions for the least-cost option selector, bound to the top level.
`include "assert_macros.svh"

module lcos_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input lcos_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input lcos_pkg::out_item_t m_data
);
    import lcos_pkg::*;

    // A stalled result keeps its contents.
    `LCOS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // A report transaction never produces a result.
    `LCOS_ASSERT(a_report_silent, aclk, aresetn, s_valid && s_ready && (s_data.action == ACT_REPORT) && !m_valid |=> !m_valid, "report produced a result")

    // A request keeps the block busy until its ids are handed over.
    `LCOS_ASSERT(a_request_busy, aclk, aresetn, s_valid && s_ready && (s_data.action == ACT_REQUEST) |=> !s_ready, "request accepted without going busy")

    // Within a multi-id answer the next id follows as soon as one is taken.
    `LCOS_ASSERT(a_burst_follows, aclk, aresetn, m_valid && m_ready && !m_data.last |=> m_valid, "gap inside a multi-id answer")

    // Reset empties the output register.
    `LCOS_ASSERT_NORST(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind least_cost_option_selector lcos_checker u_lcos_checker (.*);

// ===== dv/least_cost_option_selector_check.sv =====
// Checker for the least-cost option selector: predicts chosen ids and compares results.
`timescale 1ns / 100ps

module least_cost_option_selector_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lcos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcos_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  lcos_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  lcos_pkg::out_item_t             m_data,
    output int                              error_count,
    output int                              pending_results
);
    import lcos_pkg::*;

    localparam int COST_W = 48;
    localparam logic [COST_W-1:0]    COST_CEIL = '1;
    localparam logic [REQ_CNT_W-1:0] REQ_CEIL  = '1;

    logic [CNT_W-1:0]    count_reg;
    logic                mode_reg;
    logic [ROUNDS_W-1:0] rounds_reg;

    logic [ID_W-1:0]      rank [NUM_IDS];
    logic [COST_W-1:0]    total [NUM_IDS];
    logic [REQ_CNT_W-1:0] select_requests;
    logic [ID_W-1:0]      locked_id;
    logic                 locked;

    out_item_t expected_ids[$];
    int        misses = 0;

    function automatic int usable_options();
        int n;
        n = int'(count_reg);
        if (n < 1) n = 1;
        if (n > NUM_IDS) n = NUM_IDS;
        return n;
    endfunction

    function automatic void reset_ranks();
        for (int i = 0; i < NUM_IDS; i++) rank[i] = i[ID_W-1:0];
    endfunction

    function automatic void add_cost(logic [ID_W-1:0] id, logic [TICKS_W-1:0] ticks);
        logic [COST_W:0] sum;
        sum = total[id] + ticks;
        total[id] = sum[COST_W] ? COST_CEIL : sum[COST_W-1:0];
    endfunction

    // The charged front entry goes back behind every entry that costs no more.
    // The search is bounded, so an unsorted list still ends in a placement.
    function automatic void move_front_back(int n);
        logic [COST_W-1:0] c0;
        logic [ID_W-1:0]   front;
        int lo, hi, mid;
        if (n < 2) return;
        c0 = total[rank[0]];
        if (!(c0 > total[rank[1]])) return;
        lo = 0;
        hi = n;
        mid = 0;
        for (int guard = 0; guard < 128; guard++) begin
            mid = (lo + hi) / 2;
            if (total[rank[mid]] <= c0) lo = mid; else hi = mid;
            if (mid >= n - 1) break;
            if (total[rank[mid]] <= c0 && c0 < total[rank[mid + 1]]) break;
        end
        front = rank[0];
        for (int i = 0; i < mid; i++) rank[i] = rank[i + 1];
        rank[mid] = front;
    endfunction

    function automatic logic [ID_W-1:0] cheapest(int n);
        int best;
        best = 0;
        for (int i = 1; i < n; i++)
            if (total[i] < total[best]) best = i;
        return best[ID_W-1:0];
    endfunction

    function automatic void push_id(logic [ID_W-1:0] id, logic is_last);
        out_item_t r;
        r.chosen_id = id;
        r.last      = is_last;
        expected_ids = {expected_ids, r};
    endfunction

    function automatic void predict_choice(in_item_t item);
        int n;
        bit testing;
        n = usable_options();
        if (item.action == ACT_REPORT) begin
            if (mode_reg == MODE_SWITCH) begin
                add_cost(rank[0], item.cost_ticks);
                move_front_back(n);
            end else if (int'(item.option_id) < n) begin
                add_cost(item.option_id, item.cost_ticks);
            end
        end else if (mode_reg == MODE_SWITCH) begin
            push_id(rank[0], 1'b1);
        end else begin
            testing = select_requests < {1'b0, rounds_reg};
            if (select_requests != REQ_CEIL) select_requests++;
            if (testing) begin
                for (int i = 0; i < n; i++) push_id(i[ID_W-1:0], i == n - 1);
            end else begin
                if (!locked) begin
                    locked_id = cheapest(n);
                    locked    = 1'b1;
                end
                push_id(locked_id, 1'b1);
            end
        end
    endfunction

    function automatic void flag(string msg);
        misses++;
        if (misses <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            count_reg       = 5'd1;
            mode_reg        = MODE_SWITCH;
            rounds_reg      = '0;
            reset_ranks();
            for (int i = 0; i < NUM_IDS; i++) total[i] = '0;
            select_requests = '0;
            locked_id       = '0;
            locked          = 1'b0;
            expected_ids.delete();
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_ids.size() == 0) begin
                    flag($sformatf("result id %0d last %b with nothing expected",
                                   m_data.chosen_id, m_data.last));
                end else begin
                    want = expected_ids.pop_front();
                    if (m_data.chosen_id !== want.chosen_id || m_data.last !== want.last)
                        flag($sformatf("expected id %0d last %b, got id %0d last %b",
                                       want.chosen_id, want.last,
                                       m_data.chosen_id, m_data.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_OPTION_COUNT: begin
                        count_reg = cfg_wdata[CNT_W-1:0];
                        reset_ranks();
                    end
                    REG_POLICY_MODE: mode_reg = cfg_wdata[0];
                    REG_TEST_ROUNDS: rounds_reg = cfg_wdata[ROUNDS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_choice(s_data);
        end
        pending_results <= expected_ids.size();
        error_count     <= misses;
    end

endmodule

// ===== dv/least_cost_option_selector_test.sv =====
// Testbench top for the least-cost option selector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module least_cost_option_selector_test;
    import lcos_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_PCT      = 37;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  steady    = 1'b0;
    int                    error_count;
    int                    pending_results;

    always #6 aclk = ~aclk;

    least_cost_option_selector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    least_cost_option_selector_check u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    always @(posedge aclk) m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    function automatic in_item_t make_item(logic act, logic [ID_W-1:0] id,
                                           logic [TICKS_W-1:0] ticks);
        in_item_t item;
        item.action     = act;
        item.option_id  = id;
        item.cost_ticks = ticks;
        return item;
    endfunction

    // Mostly small costs so that ties and reordering happen often.
    function automatic logic [TICKS_W-1:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return $urandom_range(0, 20);
            6, 7:    return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Valid stays high across back-to-back transactions and drops only for a gap.
    task automatic send(input in_item_t item);
        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Reports give no result, so a report may still be in work after the last id.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(input int items);
        logic [CFG_DATA_W-1:0] count_val;
        logic [CFG_DATA_W-1:0] rounds_val;
        case ($urandom_range(0, 9))
            0:       count_val = 16'd0;
            1:       count_val = CFG_DATA_W'($urandom_range(17, 31));
            2:       count_val = 16'd16;
            3:       count_val = 16'd1;
            default: count_val = CFG_DATA_W'($urandom_range(2, 16));
        endcase
        case ($urandom_range(0, 9))
            0:       rounds_val = 16'hFFFF;
            1:       rounds_val = 16'd0;
            default: rounds_val = CFG_DATA_W'($urandom_range(0, 30));
        endcase
        if ($urandom_range(0, 1)) write_reg(REG_OPTION_COUNT, count_val);
        if ($urandom_range(0, 1))
            write_reg(REG_POLICY_MODE, $urandom_range(0, 1) ? 16'(MODE_SELECT) : 16'(MODE_SWITCH));
        if ($urandom_range(0, 1)) write_reg(REG_TEST_ROUNDS, rounds_val);
        for (int i = 0; i < items; i++) begin
            send(make_item($urandom_range(0, 1) ? ACT_REPORT : ACT_REQUEST,
                           ID_W'($urandom_range(0, 15)), pick_ticks()));
            if ($urandom_range(0, 29) == 0) drain();
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single option after reset in switch mode: the front never moves.
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        send(make_item(ACT_REPORT, 4'd15, 32'hFFFF_FFFF));
        send(make_item(ACT_REQUEST, 4'd15, 32'hFFFF_FFFF));
        drain();

        // A count of zero behaves as one option.
        write_reg(REG_OPTION_COUNT, 16'd0);
        send(make_item(ACT_REPORT, 4'd9, 32'd7));
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        drain();

        // A count above sixteen is clamped; the costly front entry gets reinserted.
        write_reg(REG_OPTION_COUNT, 16'd31);
        send(make_item(ACT_REPORT, 4'd3, 32'd0));
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        send(make_item(ACT_REPORT, 4'd0, 32'd5));
        send(make_item(ACT_REPORT, 4'd0, 32'd5));
        send(make_item(ACT_REPORT, 4'd0, 32'd0));
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        drain();

        // Select mode: two test rounds, a report for an unused id, two reports of equal ticks.
        write_reg(REG_POLICY_MODE, 16'(MODE_SELECT));
        write_reg(REG_TEST_ROUNDS, 16'd2);
        write_reg(REG_OPTION_COUNT, 16'd3);
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        send(make_item(ACT_REPORT, 4'd15, 32'hFFFF_FFFF));
        send(make_item(ACT_REPORT, 4'd1, 32'd1000));
        send(make_item(ACT_REPORT, 4'd2, 32'd1000));
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        drain();

        // The committed choice survives a smaller count.
        write_reg(REG_OPTION_COUNT, 16'd1);
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        drain();

        // The largest round count puts requests back into testing.
        write_reg(REG_TEST_ROUNDS, 16'hFFFF);
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        drain();
        write_reg(REG_OPTION_COUNT, 16'd16);
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        drain();

        for (int p = 0; p < 4; p++) random_phase(25);

        // A stretch with no idling: costly reports on a single option in switch mode.
        steady <= 1'b1;
        write_reg(REG_POLICY_MODE, 16'(MODE_SWITCH));
        write_reg(REG_OPTION_COUNT, 16'd1);
        for (int i = 0; i < 10; i++) send(make_item(ACT_REPORT, 4'd0, 32'hFFFF_FFFF));
        send(make_item(ACT_REQUEST, 4'd0, 32'd0));
        drain();
        write_reg(REG_OPTION_COUNT, 16'd16);
        random_phase(25);
        steady <= 1'b0;

        for (int p = 0; p < 2; p++) random_phase(25);

        if (error_count == 0 && pending_results == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
